// ===== src/tcc_pkg.sv =====
// Shared types and codes for the text console engine.
`default_nettype none

package tcc_pkg;

    localparam int MEM_AW = 16;

    localparam logic [1:0] REQ_PUT  = 2'd0;
    localparam logic [1:0] REQ_UP   = 2'd1;
    localparam logic [1:0] REQ_DOWN = 2'd2;
    localparam logic [1:0] REQ_READ = 2'd3;

    localparam logic [7:0] CH_NL = 8'd10;
    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_SP = 8'd32;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [MEM_AW-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// ===== src/text_console_cursor_scroll.sv =====
// Text console engine top level: sequencer plus cell memory.
// A put runs one line clear per auto-scroll pass; an overflow adds a copy walk
// and one line clear.
// One request at a time; the result register frees input while a result waits.
// After reset all BUFFER_LINES*SCREEN_COLS cells are filled with spaces
// (5120 by default) before the first request is taken.
`default_nettype none

module text_console_cursor_scroll
    import tcc_pkg::*;
#(
    parameter int SCREEN_COLS  = 80,
    parameter int SCREEN_ROWS  = 25,
    parameter int BUFFER_LINES = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  ch,
    input  wire logic [12:0] read_addr,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [12:0]      cursor_pos,
    output logic [12:0]      view_start,
    output logic             buffer_full,
    output logic [7:0]       read_char
);

    mem_req_t   mem_req;
    logic [7:0] mem_rdata;

    tcc_engine #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .BUFFER_LINES(BUFFER_LINES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .ch         (ch),
        .read_addr  (read_addr),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cursor_pos (cursor_pos),
        .view_start (view_start),
        .buffer_full(buffer_full),
        .read_char  (read_char),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    tcc_cell_mem #(
        .DEPTH(BUFFER_LINES * SCREEN_COLS)
    ) u_mem (
        .clk  (clk),
        .req  (mem_req),
        .rdata(mem_rdata)
    );

endmodule

`default_nettype wire

// ===== src/tcc_cell_mem.sv =====
// Character cell memory: one write port, one registered read port.
`default_nettype none

module tcc_cell_mem
    import tcc_pkg::*;
#(
    parameter int DEPTH = 5120
)
(
    input  wire logic     clk,
    input  wire mem_req_t req,
    output logic [7:0]    rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr[AW-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/tcc_engine.sv =====
// Request sequencer: cursor, view and overflow state, copy and line-clear walks.
`default_nettype none

module tcc_engine
    import tcc_pkg::*;
#(
    parameter int SCREEN_COLS  = 80,
    parameter int SCREEN_ROWS  = 25,
    parameter int BUFFER_LINES = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  ch,
    input  wire logic [12:0] read_addr,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [12:0]      cursor_pos,
    output logic [12:0]      view_start,
    output logic             buffer_full,
    output logic [7:0]       read_char,
    output mem_req_t         mem_req,
    input  wire logic [7:0]  mem_rdata
);

    localparam int COLS      = SCREEN_COLS;
    localparam int VIEW_ROWS = (SCREEN_ROWS < BUFFER_LINES) ? SCREEN_ROWS : BUFFER_LINES;
    localparam int NCELLS    = BUFFER_LINES * COLS;
    localparam int SCR       = VIEW_ROWS * COLS;
    localparam int CW        = $clog2(NCELLS) + 1;
    localparam int MW        = $clog2(NCELLS);
    localparam int LW        = $clog2(BUFFER_LINES + 1);
    localparam int XW        = $clog2(COLS);
    localparam int COPY_LEN  = SCR - COLS;
    localparam int COPY_SRC  = NCELLS + COLS - SCR;

    localparam logic [2:0] S_CLR    = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RD     = 3'd2;
    localparam logic [2:0] S_OVF    = 3'd3;
    localparam logic [2:0] S_COPY   = 3'd4;
    localparam logic [2:0] S_BLANK  = 3'd5;
    localparam logic [2:0] S_SCROLL = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [XW-1:0] col_reg, col_next;
    logic [LW-1:0] line_reg, line_next;
    logic [CW-1:0] view_reg, view_next;
    logic          full_reg, full_next;
    logic [MW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] pass_reg, pass_next;
    logic [7:0]    rd_reg, rd_next;
    logic          out_valid_reg, out_valid_next;
    logic [12:0]   cursor_pos_reg, view_start_reg;
    logic          buffer_full_reg;
    logic [7:0]    read_char_reg;
    logic          load_out;

    logic [CW-1:0] newest, top_scr, up_view, down_view, near_line, oldest, blank_addr;

    // View movement rules, applied to the present cursor and view.
    always_comb
    begin
        newest  = cursor_reg - CW'(col_reg);
        top_scr = view_reg + CW'(SCR);
        up_view = view_reg;
        if (!full_reg && newest >= top_scr)
        begin
            up_view = view_reg + CW'(COLS);
        end
        else if (full_reg && (top_scr - CW'(COLS)) != newest)
        begin
            up_view = (top_scr == CW'(NCELLS)) ? '0 : view_reg + CW'(COLS);
        end

        near_line = newest + CW'(COLS);
        if (!full_reg)
            oldest = '0;
        else if (near_line >= CW'(NCELLS))
            oldest = near_line - CW'(NCELLS);
        else
            oldest = near_line;

        down_view = view_reg;
        if (!full_reg && view_reg != '0)
        begin
            down_view = view_reg - CW'(COLS);
        end
        else if (full_reg && view_reg != oldest)
        begin
            if (cursor_reg >= CW'(NCELLS - SCR))
            begin
                if (view_reg != '0)
                    down_view = view_reg - CW'(COLS);
            end
            else if (view_reg == '0)
                down_view = CW'(NCELLS - SCR);
            else
                down_view = view_reg - CW'(COLS);
        end

        blank_addr = cursor_reg + CW'(cnt_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        view_next      = view_reg;
        full_next      = full_reg;
        cnt_next       = cnt_reg;
        pass_next      = pass_reg;
        rd_next        = rd_reg;
        load_out       = 1'b0;
        mem_req.we     = 1'b0;
        mem_req.waddr  = '0;
        mem_req.wdata  = CH_SP;
        mem_req.raddr  = MEM_AW'(read_addr);

        unique case (state_reg)
            S_CLR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_AW'(cnt_reg);
                if (cnt_reg == MW'(NCELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rd_next = '0;
                    case (req_type)
                        REQ_PUT:
                        begin
                            state_next = S_OVF;
                            if (ch == CH_NL)
                            begin
                                cursor_next = newest + CW'(COLS);
                                col_next    = '0;
                                line_next   = line_reg + 1'b1;
                            end
                            else if (ch == CH_BS)
                            begin
                                if (cursor_reg != '0)
                                begin
                                    cursor_next   = cursor_reg - 1'b1;
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = MEM_AW'(cursor_reg - 1'b1);
                                    if (col_reg == '0)
                                    begin
                                        col_next  = XW'(COLS - 1);
                                        line_next = line_reg - 1'b1;
                                    end
                                    else
                                        col_next = col_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = MEM_AW'(cursor_reg);
                                mem_req.wdata = ch;
                                cursor_next   = cursor_reg + 1'b1;
                                if (col_reg == XW'(COLS - 1))
                                begin
                                    col_next  = '0;
                                    line_next = line_reg + 1'b1;
                                end
                                else
                                    col_next = col_reg + 1'b1;
                            end
                        end
                        REQ_UP:
                        begin
                            view_next  = up_view;
                            state_next = S_DONE;
                        end
                        REQ_DOWN:
                        begin
                            view_next  = down_view;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = (32'(read_addr) < NCELLS) ? S_RD : S_DONE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                rd_next    = mem_rdata;
                state_next = S_DONE;
            end
            S_OVF:
            begin
                pass_next  = '0;
                cnt_next   = '0;
                state_next = (cursor_reg >= CW'(NCELLS)) ? S_COPY : S_SCROLL;
            end
            S_COPY:
            begin
                // Read one cell ahead, write the previous one.
                mem_req.raddr = MEM_AW'(CW'(COPY_SRC) + CW'(cnt_reg));
                if (cnt_reg != '0)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = MEM_AW'(cnt_reg - 1'b1);
                    mem_req.wdata = mem_rdata;
                end
                if (cnt_reg == MW'(COPY_LEN))
                begin
                    view_next   = '0;
                    cursor_next = CW'(SCR - COLS) + CW'(col_reg);
                    line_next   = LW'(VIEW_ROWS - 1);
                    full_next   = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_BLANK;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_BLANK:
            begin
                mem_req.waddr = MEM_AW'(blank_addr);
                mem_req.we    = (blank_addr < CW'(NCELLS));
                if (cnt_reg == MW'(COLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_SCROLL;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_SCROLL:
            begin
                if (pass_reg != LW'(BUFFER_LINES)
                    && (cursor_reg >= top_scr || cursor_reg < view_reg))
                begin
                    view_next  = up_view;
                    pass_next  = pass_reg + 1'b1;
                    cnt_next   = '0;
                    state_next = S_BLANK;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cursor_reg    <= '0;
            col_reg       <= '0;
            line_reg      <= '0;
            view_reg      <= '0;
            full_reg      <= 1'b0;
            cnt_reg       <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            view_reg      <= view_next;
            full_reg      <= full_next;
            cnt_reg       <= cnt_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
        if (load_out)
        begin
            cursor_pos_reg  <= 13'(cursor_reg);
            view_start_reg  <= 13'(view_reg);
            buffer_full_reg <= full_reg;
            read_char_reg   <= rd_reg;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign cursor_pos  = cursor_pos_reg;
    assign view_start  = view_start_reg;
    assign buffer_full = buffer_full_reg;
    assign read_char   = read_char_reg;

endmodule

`default_nettype wire

// ===== src/tcc_checker.sv =====
// Port-level checks for the text console engine, bound to the top level.
`default_nettype none

module tcc_checker #(
    parameter int SCREEN_COLS  = 80,
    parameter int SCREEN_ROWS  = 25,
    parameter int BUFFER_LINES = 64
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [12:0] cursor_pos,
    input wire logic        buffer_full
);

    localparam int NCELLS = BUFFER_LINES * SCREEN_COLS;

    logic seen_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_full_reg <= 1'b0;
        else if (out_valid && out_ready && buffer_full)
            seen_full_reg <= 1'b1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_pos))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_full_reg |-> buffer_full)
        else $error("full flag dropped");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (NCELLS > 8192) || (32'(cursor_pos) < NCELLS))
        else $error("cursor outside store");

endmodule

bind text_console_cursor_scroll tcc_checker #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .BUFFER_LINES(BUFFER_LINES)
) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_pos (cursor_pos),
    .buffer_full(buffer_full)
);

`default_nettype wire

// ===== tb/text_console_cursor_scroll_chk.sv =====
// Request/result checker for the text console engine.
`timescale 1ns / 100ps

module text_console_cursor_scroll_chk
    import tcc_pkg::*;
#(
    parameter int SCREEN_COLS  = 80,
    parameter int SCREEN_ROWS  = 25,
    parameter int BUFFER_LINES = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  ch,
    input  wire logic [12:0] read_addr,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [12:0] cursor_pos,
    input  wire logic [12:0] view_start,
    input  wire logic        buffer_full,
    input  wire logic [7:0]  read_char,
    output int               fail_count,
    output int               pending
);

    localparam int VROWS  = (SCREEN_ROWS < BUFFER_LINES) ? SCREEN_ROWS : BUFFER_LINES;
    localparam int NCELLS = BUFFER_LINES * SCREEN_COLS;
    localparam int SCELLS = VROWS * SCREEN_COLS;
    localparam int COLS   = SCREEN_COLS;

    typedef struct packed {
        logic [12:0] cursor;
        logic [12:0] view;
        logic        full;
        logic [7:0]  rd;
    } status_t;

    logic [7:0] cells [NCELLS];
    int         cur;
    int         top;
    bit         wrapped;
    status_t    status_q[$];

    function automatic void blank_line(int pos);
        for (int i = 0; i < COLS; i++)
            if (pos + i < NCELLS)
                cells[pos + i] = CH_SP;
    endfunction

    function automatic void scroll_up();
        int newest;
        newest = cur / COLS * COLS;
        if (!wrapped && newest >= top + SCELLS)
            top = top + COLS;
        else if (wrapped && top + SCELLS - COLS != newest)
            top = (top + SCELLS == NCELLS) ? 0 : top + COLS;
    endfunction

    function automatic void scroll_down();
        int newest;
        int oldest;
        newest = cur / COLS * COLS;
        oldest = wrapped ? (newest + COLS) % NCELLS : 0;
        if (!wrapped && top > 0)
            top = top - COLS;
        else if (wrapped && top != oldest) begin
            if (cur >= NCELLS - SCELLS) begin
                if (top != 0)
                    top = top - COLS;
            end
            else if (top == 0)
                top = NCELLS - SCELLS;
            else
                top = top - COLS;
        end
    endfunction

    function automatic void put_byte(logic [7:0] c);
        int col;
        int src;
        if (cur >= NCELLS)
            cur = 0;
        if (c == CH_NL)
            cur = (cur / COLS + 1) * COLS;
        else if (c == CH_BS) begin
            if (cur > 0) begin
                cur--;
                cells[cur] = CH_SP;
            end
        end
        else begin
            cells[cur] = c;
            cur++;
        end
        if (cur >= NCELLS) begin
            col = cur % COLS;
            src = (cur / COLS + 1) * COLS - SCELLS;
            for (int i = 0; i < SCELLS - COLS; i++)
                cells[i] = cells[src + i];
            top = 0;
            cur = SCELLS - COLS + col;
            blank_line(cur);
            wrapped = 1;
        end
        for (int p = 0; p < BUFFER_LINES; p++) begin
            if (!(cur >= top + SCELLS || cur < top))
                break;
            scroll_up();
            blank_line(cur);
        end
    endfunction

    function automatic status_t console_step(logic [1:0] rt, logic [7:0] c, logic [12:0] a);
        status_t s;
        s.rd = '0;
        case (rt)
            REQ_PUT:  put_byte(c);
            REQ_UP:   scroll_up();
            REQ_DOWN: scroll_down();
            default:  if (a < NCELLS) s.rd = cells[a];
        endcase
        s.cursor = cur[12:0];
        s.view   = top[12:0];
        s.full   = wrapped;
        return s;
    endfunction

    assign pending = status_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        status_t want;
        if (!rst_n) begin
            for (int i = 0; i < NCELLS; i++)
                cells[i] = CH_SP;
            cur = 0;
            top = 0;
            wrapped = 0;
            status_q.delete();
            fail_count <= 0;
        end
        else begin
            if (in_valid && in_ready)
                status_q.push_back(console_step(req_type, ch, read_addr));
            if (out_valid && out_ready) begin
                if (status_q.size() == 0) begin
                    $display("%0t: result with no request pending", $time);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = status_q.pop_front();
                    if (want != {cursor_pos, view_start, buffer_full, read_char}) begin
                        $display("%0t: mismatch exp cur=%0d view=%0d full=%0d rd=%0d",
                                 $time, want.cursor, want.view, want.full, want.rd);
                        $display("%0t:          act cur=%0d view=%0d full=%0d rd=%0d",
                                 $time, cursor_pos, view_start, buffer_full, read_char);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/text_console_cursor_scroll_tb.sv =====
// Stimulus and verdict for the text console engine.
`timescale 1ns / 100ps

module text_console_cursor_scroll_tb;
    import tcc_pkg::*;

    localparam int NCELLS = 5120;
    localparam int WATCH_LIMIT = 400000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [1:0]  req_type = REQ_PUT;
    logic [7:0]  ch = 0;
    logic [12:0] read_addr = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [12:0] cursor_pos;
    logic [12:0] view_start;
    logic        buffer_full;
    logic [7:0]  read_char;
    int          fail_count;
    int          pending;
    int          send_idle = 0;
    int          recv_idle = 0;
    bit          hold_off = 0;
    int          quiet = 0;

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    text_console_cursor_scroll DUT (.*);
    text_console_cursor_scroll_chk CHK (.*);

    always @(posedge clk)
        out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);

    // Cut the run short if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WATCH_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Leave valid high on return; the next request or the caller drops it.
    task automatic send(logic [1:0] rt, logic [7:0] c, logic [12:0] a);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        req_type <= rt;
        ch <= c;
        read_addr <= a;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random(int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 45)
                send(REQ_PUT, 8'($urandom_range(33, 126)), 13'($urandom));
            else if (k < 60)
                send(REQ_PUT, CH_NL, 13'($urandom));
            else if (k < 66)
                send(REQ_PUT, CH_BS, 13'($urandom));
            else if (k < 70)
                send(REQ_PUT, 8'($urandom), 13'($urandom));
            else if (k < 78)
                send(REQ_UP, 8'($urandom), 13'($urandom));
            else if (k < 86)
                send(REQ_DOWN, 8'($urandom), 13'($urandom));
            else if (k < 97)
                send(REQ_READ, 8'($urandom), 13'($urandom_range(NCELLS - 1)));
            else
                send(REQ_READ, 8'($urandom), 13'($urandom));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // Directed: edges, backspace at origin, scrolls at reset, reads.
        send(REQ_PUT, CH_BS, 13'd0);
        send(REQ_UP, 8'hFF, 13'h1FFF);
        send(REQ_DOWN, 8'd0, 13'd0);
        send(REQ_PUT, 8'hFF, 13'd0);
        send(REQ_PUT, 8'h00, 13'd0);
        send(REQ_PUT, 8'h55, 13'd0);
        send(REQ_PUT, 8'hAA, 13'd0);
        send(REQ_READ, 8'd0, 13'd0);
        send(REQ_READ, 8'd0, 13'd3);
        send(REQ_READ, 8'd0, 13'(NCELLS - 1));
        send(REQ_READ, 8'd0, 13'(NCELLS));
        send(REQ_READ, 8'd0, 13'h1FFF);
        send(REQ_PUT, CH_BS, 13'd0);
        send(REQ_PUT, CH_NL, 13'd0);
        send(REQ_DOWN, 8'd0, 13'd0);
        // Push through the bottom of the screen and past the end of the buffer.
        for (int i = 0; i < 70; i++)
            send(REQ_PUT, CH_NL, 13'd0);
        send(REQ_UP, 8'd0, 13'd0);
        send(REQ_DOWN, 8'd0, 13'd0);
        send(REQ_DOWN, 8'd0, 13'd0);

        send_idle = 12;
        recv_idle = 45;
        send_random(500);

        // Hold results back so the input stalls.
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
            begin
                send_random(20);
                in_valid <= 0;
            end
        join

        send_idle = 45;
        recv_idle = 12;
        send_random(500);
        send_idle = 0;
        recv_idle = 0;
        send_random(560);
        in_valid <= 0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tcc_pkg.sv
src/tcc_cell_mem.sv
src/tcc_engine.sv
src/text_console_cursor_scroll.sv
src/tcc_checker.sv
tb/text_console_cursor_scroll_chk.sv
tb/text_console_cursor_scroll_tb.sv
